@@ design/uesc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uesc_pkg
// Shared types and constants for the escape-to-UTF-8 decoder: request
// payloads, piece descriptors passed from the parser to the byte emitter.
// ----------------------------------------------------------------------------
package uesc_pkg;

	// Default depth of the descriptor queue between parser and emitter
	localparam int QUEUE_DEPTH = 4;

	// Number of pieces one input byte can produce
	localparam int PIECES = 3;

	// Maximum UTF-8 bytes one descriptor expands to
	localparam int MAX_BYTES = 6;

	// Piece kinds
	localparam logic [1:0] PK_NONE = 2'd0;  // empty slot
	localparam logic [1:0] PK_BYTE = 2'd1;  // one literal byte
	localparam logic [1:0] PK_CODE = 2'd2;  // 16-bit code, 0..3 bytes of UTF-8
	localparam logic [1:0] PK_PAIR = 2'd3;  // 21-bit code point, 4 bytes of UTF-8

	// Input request: one byte of escaped text
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_item_t;

	// Output request: one UTF-8 byte or a bare end marker
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_text;
	} out_item_t;

	// One unit of output work; value layout depends on kind
	typedef struct packed {
		logic [1:0]  kind;
		logic [20:0] value;
	} piece_t;

	// Queue entry: ordered pieces (slot 0 first) and the end-of-text flag
	typedef struct packed {
		piece_t [PIECES-1:0] pieces;
		logic                end_of_text;
	} entry_t;

endpackage : uesc_pkg
`default_nettype wire

@@ design/uesc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uesc_front
// Escape parser: tracks backslash / hex-body state and the held high
// surrogate, and turns each accepted byte into a descriptor of output pieces.
// ----------------------------------------------------------------------------
module uesc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              text_valid,
	output logic                   text_stall,
	input  uesc_pkg::in_item_t     text,
	input  wire logic              q_full,
	output logic                   q_push,
	output uesc_pkg::entry_t       q_entry
);
	import uesc_pkg::*;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_BSLASH = 3'd1;
	localparam logic [2:0] MODE_HEX    = 3'd2;

	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_LU  = 8'h75;
	localparam logic [7:0] CH_UU  = 8'h55;

	localparam logic [5:0] HIGH_TAG = 6'b110110;  // 0xD800..0xDBFF
	localparam logic [5:0] LOW_TAG  = 6'b110111;  // 0xDC00..0xDFFF

	typedef struct packed {
		piece_t [PIECES-1:0] p;
		logic [1:0]          n;
	} plist_t;

	// Append one piece to the list
	function automatic plist_t plist_add(plist_t l, logic [1:0] kind, logic [20:0] v);
		plist_t r;
		r = l;
		if (r.n != 2'd3) begin
			r.p[r.n].kind  = kind;
			r.p[r.n].value = v;
			r.n            = r.n + 2'd1;
		end
		return r;
	endfunction

	// {is_hex, nibble}
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	logic [2:0]  mode_q, mode_n;
	logic [15:0] hv_q, hv_n;
	logic [2:0]  hc_q, hc_n;
	logic        hs_q, hs_n;
	logic [9:0]  hb_q, hb_n;
	logic        held_q, held_n;
	logic        adj_q, adj_n;
	plist_t      pl;
	logic        accept;

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;

	// Next state and output pieces for the byte on the input
	always_comb begin
		logic [4:0]  dig;
		logic [15:0] c;
		logic [10:0] cp_hi;
		mode_n = mode_q;
		hv_n   = hv_q;
		hc_n   = hc_q;
		hs_n   = hs_q;
		hb_n   = hb_q;
		held_n = held_q;
		adj_n  = adj_q;
		pl     = '0;
		dig    = hex_digit(text.text_byte);
		c      = 16'd0;
		cp_hi  = 11'd0;

		if (mode_q == MODE_BSLASH) begin
			if (text.text_byte == CH_LU || text.text_byte == CH_UU) begin
				mode_n = MODE_HEX;
				hv_n   = 16'd0;
				hc_n   = 3'd0;
				hs_n   = 1'b0;
				adj_n  = held_q;
			end else if (text.text_byte == CH_BSL) begin
				if (held_n) begin
					pl     = plist_add(pl, PK_CODE, {5'd0, HIGH_TAG, hb_n});
					held_n = 1'b0;
				end
				pl = plist_add(pl, PK_BYTE, {13'd0, CH_BSL});
			end else begin
				if (held_n) begin
					pl     = plist_add(pl, PK_CODE, {5'd0, HIGH_TAG, hb_n});
					held_n = 1'b0;
				end
				pl     = plist_add(pl, PK_BYTE, {13'd0, CH_BSL});
				pl     = plist_add(pl, PK_BYTE, {13'd0, text.text_byte});
				mode_n = MODE_NORMAL;
			end
		end else if (mode_q == MODE_HEX) begin
			// digits stop at the first non-hex byte; the body length is fixed
			if (!hs_n) begin
				if (!dig[4]) begin
					hs_n = 1'b1;
				end else begin
					hv_n = {hv_n[11:0], dig[3:0]};
				end
			end
			hc_n = hc_n + 3'd1;
		end else begin
			mode_n = MODE_NORMAL;
			if (text.text_byte == CH_BSL) begin
				mode_n = MODE_BSLASH;
			end else begin
				if (held_n) begin
					pl     = plist_add(pl, PK_CODE, {5'd0, HIGH_TAG, hb_n});
					held_n = 1'b0;
				end
				pl = plist_add(pl, PK_BYTE, {13'd0, text.text_byte});
			end
		end

		// Escape complete (full body, or cut short by the end of text)
		if (mode_n == MODE_HEX && (hc_n == 3'd4 || text.is_last)) begin
			c = hv_n;
			if (held_n && adj_n && c[15:10] == LOW_TAG) begin
				cp_hi  = {1'b0, hb_n} + 11'h040;
				pl     = plist_add(pl, PK_PAIR, {cp_hi, c[9:0]});
				held_n = 1'b0;
			end else begin
				if (held_n) begin
					pl     = plist_add(pl, PK_CODE, {5'd0, HIGH_TAG, hb_n});
					held_n = 1'b0;
				end
				if (c[15:10] == HIGH_TAG) begin
					hb_n   = c[9:0];
					held_n = 1'b1;
				end else if (c != 16'd0) begin
					pl = plist_add(pl, PK_CODE, {5'd0, c});
				end
			end
			hv_n   = 16'd0;
			hc_n   = 3'd0;
			hs_n   = 1'b0;
			adj_n  = 1'b0;
			mode_n = MODE_NORMAL;
		end

		// End of text: flush everything and return to reset state
		if (text.is_last) begin
			if (mode_n == MODE_BSLASH) begin
				if (held_n) begin
					pl     = plist_add(pl, PK_CODE, {5'd0, HIGH_TAG, hb_n});
					held_n = 1'b0;
				end
				pl = plist_add(pl, PK_BYTE, {13'd0, CH_BSL});
			end
			if (held_n) begin
				pl     = plist_add(pl, PK_CODE, {5'd0, HIGH_TAG, hb_n});
				held_n = 1'b0;
			end
			mode_n = MODE_NORMAL;
			hv_n   = 16'd0;
			hc_n   = 3'd0;
			hs_n   = 1'b0;
			hb_n   = 10'd0;
			adj_n  = 1'b0;
		end
	end

	// Queue write: only when there is output work or an end marker
	assign q_push              = accept && (pl.n != 2'd0 || text.is_last);
	assign q_entry.pieces      = pl.p;
	assign q_entry.end_of_text = text.is_last;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			hv_q   <= 16'd0;
			hc_q   <= 3'd0;
			hs_q   <= 1'b0;
			hb_q   <= 10'd0;
			held_q <= 1'b0;
			adj_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			hv_q   <= hv_n;
			hc_q   <= hc_n;
			hs_q   <= hs_n;
			hb_q   <= hb_n;
			held_q <= held_n;
			adj_q  <= adj_n;
		end
	end

endmodule : uesc_front
`default_nettype wire

@@ design/uesc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uesc_queue
// Small first-in first-out queue of piece descriptors between the parser
// and the byte emitter.
// ----------------------------------------------------------------------------
module uesc_queue #(
	parameter int DEPTH = uesc_pkg::QUEUE_DEPTH  // 2..16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  uesc_pkg::entry_t   push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output uesc_pkg::entry_t   head
);
	import uesc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule : uesc_queue
`default_nettype wire

@@ design/uesc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uesc_back
// Byte emitter: expands the head descriptor into UTF-8 bytes and sends them
// one per cycle while utf8_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module uesc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  uesc_pkg::entry_t    q_head,
	output logic                q_pop,
	output logic                utf8_valid,
	input  wire logic           utf8_stall,
	output uesc_pkg::out_item_t utf8
);
	import uesc_pkg::*;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} enc_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] b;
		logic [2:0]                n;
	} exp_t;

	// UTF-8 encoding of one piece
	function automatic enc_t encode(piece_t p);
		enc_t r;
		r = '0;
		unique case (p.kind)
			PK_BYTE: begin
				r.len  = 3'd1;
				r.b[0] = p.value[7:0];
			end
			PK_CODE: begin
				if (p.value[15:0] == 16'd0) begin
					r.len = 3'd0;
				end else if (p.value[15:7] == 9'd0) begin
					r.len  = 3'd1;
					r.b[0] = p.value[7:0];
				end else if (p.value[15:11] == 5'd0) begin
					r.len  = 3'd2;
					r.b[0] = {3'b110, p.value[10:6]};
					r.b[1] = {2'b10, p.value[5:0]};
				end else begin
					r.len  = 3'd3;
					r.b[0] = {4'b1110, p.value[15:12]};
					r.b[1] = {2'b10, p.value[11:6]};
					r.b[2] = {2'b10, p.value[5:0]};
				end
			end
			PK_PAIR: begin
				r.len  = 3'd4;
				r.b[0] = {5'b11110, p.value[20:18]};
				r.b[1] = {2'b10, p.value[17:12]};
				r.b[2] = {2'b10, p.value[11:6]};
				r.b[3] = {2'b10, p.value[5:0]};
			end
			PK_NONE: r.len = 3'd0;
		endcase
		return r;
	endfunction

	// Concatenate the encoded pieces in order
	function automatic exp_t expand(entry_t e);
		exp_t       r;
		enc_t       en;
		logic [3:0] pos;
		logic [3:0] at;
		r   = '0;
		pos = 4'd0;
		for (int i = 0; i < PIECES; i++) begin
			en = encode(e.pieces[i]);
			for (int k = 0; k < 4; k++) begin
				at = pos + 4'(k);
				if (3'(k) < en.len && at < 4'(MAX_BYTES)) begin
					r.b[at[2:0]] = en.b[k];
				end
			end
			pos = pos + {1'b0, en.len};
		end
		r.n = pos[2:0];
		return r;
	endfunction

	exp_t      ex;
	logic [2:0] idx_q;
	logic       ov_q;
	out_item_t  od_q;
	logic       can_load;
	logic       last_byte;
	logic       emit;
	out_item_t  next_item;

	assign ex        = expand(q_head);
	assign can_load  = !ov_q || !utf8_stall;
	assign last_byte = (ex.n == 3'd0) || (idx_q == ex.n - 3'd1);
	assign emit      = q_valid && can_load && (ex.n != 3'd0 || q_head.end_of_text);
	assign q_pop     = q_valid && can_load && last_byte;

	// Next output request: a data byte, or a bare marker for an empty text end
	always_comb begin
		if (ex.n == 3'd0) begin
			next_item.out_byte    = 8'd0;
			next_item.byte_valid  = 1'b0;
			next_item.end_of_text = 1'b1;
		end else begin
			next_item.out_byte    = ex.b[idx_q];
			next_item.byte_valid  = 1'b1;
			next_item.end_of_text = q_head.end_of_text && last_byte;
		end
	end

	// Byte index within the head descriptor, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			ov_q  <= 1'b0;
		end else if (can_load) begin
			ov_q <= emit;
			if (q_valid) begin
				idx_q <= last_byte ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			od_q <= next_item;
		end
	end

	assign utf8_valid = ov_q;
	assign utf8       = od_q;

endmodule : uesc_back
`default_nettype wire

@@ design/unicode_escape_to_utf8.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8
// Decodes \uXXXX and \UXXXX escapes in text to UTF-8, merging surrogate pairs.
// ----------------------------------------------------------------------------
// Usage:
//   text  : one escaped byte per request; is_last closes the text.
//   utf8  : one UTF-8 byte per request; end_of_text marks the final request
//           of a text, which is a bare marker (byte_valid low) when the text
//           produced no bytes.
//   A request moves when valid is high and stall is low at a clock edge.
// Path: input byte -> descriptor queue -> registered output stage.
// Throughput (receiver not stalling): one input byte per cycle while each
//   yields at most one output byte; a byte that yields N bytes (N <= 6)
//   holds the emitter until all N are sent. The output stage sends one byte
//   per cycle; the parser takes bytes until the QUEUE_DEPTH-entry queue fills.
// Reset: clears parser state, queue and output valid; no held surrogate.
// Receiver stall: the output request holds; the emitter waits, the queue
//   fills, and then text_stall rises.
// ----------------------------------------------------------------------------
module unicode_escape_to_utf8 #(
	parameter int QUEUE_DEPTH = uesc_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           text_valid,
	output logic                text_stall,
	input  uesc_pkg::in_item_t  text,
	output logic                utf8_valid,
	input  wire logic           utf8_stall,
	output uesc_pkg::out_item_t utf8
);
	import uesc_pkg::*;

	logic   q_push, q_full, q_pop, q_valid;
	entry_t q_entry, q_head;

	// Parser
	uesc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	// Descriptor queue
	uesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// Byte emitter
	uesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.utf8_valid (utf8_valid),
		.utf8_stall (utf8_stall),
		.utf8       (utf8)
	);

	// Parser never writes a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue written while full");

	// Emitter never reads an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue read while empty");

	// A request without a data byte is only ever the end marker
	assert property (@(posedge clk) disable iff (!arst_n)
		(utf8_valid && !utf8.byte_valid) |-> (utf8.end_of_text && utf8.out_byte == 8'd0))
		else $error("empty output request that is not an end marker");

endmodule : unicode_escape_to_utf8
`default_nettype wire
